### src/tokb_pkg.sv
// Package with the shared types and character constants of the tokenizer.
package tokb_pkg;

  // Character codes that the tokenizer recognizes.
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_EOL_ALT = 8'hFF;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_POW     = 8'h5E;  // '^'
  localparam logic [7:0] CH_MUL     = 8'h2A;  // '*'
  localparam logic [7:0] CH_DIV     = 8'h2F;  // '/'
  localparam logic [7:0] CH_ADD     = 8'h2B;  // '+'
  localparam logic [7:0] CH_SUB     = 8'h2D;  // '-'
  localparam logic [7:0] CH_LPAREN  = 8'h28;  // '('
  localparam logic [7:0] CH_RPAREN  = 8'h29;  // ')'
  localparam logic [7:0] CH_LSQUARE = 8'h5B;  // '['
  localparam logic [7:0] CH_RSQUARE = 8'h5D;  // ']'
  localparam logic [7:0] CH_LCURLY  = 8'h7B;  // '{'
  localparam logic [7:0] CH_RCURLY  = 8'h7D;  // '}'
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  // Token kinds.
  typedef enum logic [3:0] {
    TK_NUMBER     = 4'd0,
    TK_OPERATOR   = 4'd1,
    TK_OPEN       = 4'd2,
    TK_CLOSE      = 4'd3,
    TK_LINE_END   = 4'd4,
    TK_BAD_CHAR   = 4'd5,
    TK_UNMATCHED  = 4'd6,
    TK_MISMATCHED = 4'd7,
    TK_OVERFLOW   = 4'd8
  } tok_kind_e;

  // Operator precedence classes.
  typedef enum logic [1:0] {
    PREC_POWER  = 2'd0,
    PREC_MULDIV = 2'd1,
    PREC_ADDSUB = 2'd2,
    PREC_NONE   = 2'd3
  } prec_e;

  // Bracket codes kept on the stack.
  typedef enum logic [1:0] {
    BR_PAREN  = 2'd0,
    BR_SQUARE = 2'd1,
    BR_CURLY  = 2'd2,
    BR_NONE   = 2'd3
  } bracket_e;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned DEPTH_W = 7;

  // One result transaction.
  typedef struct packed {
    tok_kind_e            tok_kind;
    logic [VALUE_W-1:0]   tok_value;
    prec_e                prec_class;
    logic                 num_saturated;
    logic [DEPTH_W-1:0]   nest_depth;
    logic                 last;
  } tok_t;

endpackage

### src/tokb_char_if.sv
// Interface of the character input channel.
interface tokb_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;

  modport source (output valid, output in_char, input ready);
  modport sink   (input valid, input in_char, output ready);
endinterface

### src/tokb_tok_if.sv
// Interface of the token output channel.
interface tokb_tok_if;
  logic       valid;
  logic       ready;
  logic [3:0] tok_kind;
  logic [31:0] tok_value;
  logic [1:0] prec_class;
  logic       num_saturated;
  logic [6:0] nest_depth;
  logic       last;

  modport source (output valid, output tok_kind, output tok_value, output prec_class,
                  output num_saturated, output nest_depth, output last, input ready);
  modport sink   (input valid, input tok_kind, input tok_value, input prec_class,
                  input num_saturated, input nest_depth, input last, output ready);
endinterface

### src/expression_tokenizer_bracket_check.sv
// Top level of the expression tokenizer with balanced bracket check.
//
//   Channel  Dir  Payload                                         Handshake
//   char_i   in   in_char                                         valid/ready
//   tok_o    out  tok_kind tok_value prec_class num_saturated     valid/ready
//                 nest_depth last
//
// Each character is decoded in the cycle it is accepted; its zero, one or two
// tokens are registered into a four-slot result queue whose slot zero drives the output.
// One character per cycle is accepted while the queue holds two tokens or fewer.
// The bracket stack is a memory with one write and one registered read port; the
// top entry and the entry below it are kept ready so a close bracket needs no wait.
// Reset clears the accumulator, the counters and the queue; the stack memory is not cleared.
// A stalled output holds the queue, and input is refused once three tokens wait.
module expression_tokenizer_bracket_check
  import tokb_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned NUM_WIDTH   = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tokb_char_if.sink         char_i,
  tokb_tok_if.source        tok_o
);

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned QD    = 4;
  localparam int unsigned QC_W  = 3;

  // Number accumulator and flags.
  logic [NUM_WIDTH-1:0] acc_q, acc_d;
  logic                 pend_q, pend_d;
  logic                 sat_q, sat_d;

  // Bracket stack: memory plus cached top entry and the entry below it.
  logic [1:0]           stk_mem [STACK_DEPTH];
  logic [CNT_W-1:0]     stk_cnt_q, stk_cnt_d;
  logic [1:0]           top_q, top_d;
  logic [1:0]           below_q;
  logic                 stk_we;
  logic [AW-1:0]        stk_waddr;
  logic [1:0]           stk_wdata;
  logic [AW-1:0]        stk_raddr;
  logic [CNT_W-1:0]     rd_cnt;

  // Result queue, slot zero drives the output.
  tok_t                 q_q [QD];
  tok_t                 q_d [QD];
  tok_t                 q_sh [QD];
  logic [QC_W-1:0]      qcnt_q, qcnt_d;
  logic [QC_W-1:0]      qbase;
  logic                 pop;

  // Decode signals.
  logic                 accept;
  logic [7:0]           c;
  bracket_e             oc, cc;
  tok_t                 res0, res1, num_tok, chr_tok;
  logic [1:0]           nres;
  logic [NUM_WIDTH+3:0] acc_ext, prod;
  logic [NUM_WIDTH+31:0] val_ext;
  logic [CNT_W+6:0]     dep_ext, dep_inc_ext, dep_dec_ext;

  assign accept = char_i.valid && char_i.ready;
  assign c      = char_i.in_char;
  assign char_i.ready = (qcnt_q <= QC_W'(2));

  // Bracket codes of the current character.
  always_comb begin
    case (c)
      CH_LPAREN:  oc = BR_PAREN;
      CH_LSQUARE: oc = BR_SQUARE;
      CH_LCURLY:  oc = BR_CURLY;
      default:    oc = BR_NONE;
    endcase
    case (c)
      CH_RPAREN:  cc = BR_PAREN;
      CH_RSQUARE: cc = BR_SQUARE;
      CH_RCURLY:  cc = BR_CURLY;
      default:    cc = BR_NONE;
    endcase
  end

  // Next accumulator value for a digit, times ten by shifts.
  assign acc_ext = {4'd0, acc_q};
  assign prod    = (acc_ext << 3) + (acc_ext << 1) + {{NUM_WIDTH{1'b0}}, c[3:0] - 4'd0};

  // Zero extension so that narrow or wide settings map onto the fixed fields.
  assign val_ext     = {32'd0, acc_q};
  assign dep_ext     = {7'd0, stk_cnt_q};
  assign dep_inc_ext = {7'd0, stk_cnt_q + CNT_W'(1)};
  assign dep_dec_ext = {7'd0, stk_cnt_q - CNT_W'(1)};

  // Pending number token and the plain character token template.
  always_comb begin
    num_tok.tok_kind      = TK_NUMBER;
    num_tok.tok_value     = val_ext[VALUE_W-1:0];
    num_tok.prec_class    = PREC_NONE;
    num_tok.num_saturated = sat_q;
    num_tok.nest_depth    = dep_ext[DEPTH_W-1:0];
    num_tok.last          = 1'b0;
    chr_tok.tok_kind      = TK_BAD_CHAR;
    chr_tok.tok_value     = {24'd0, c};
    chr_tok.prec_class    = PREC_NONE;
    chr_tok.num_saturated = 1'b0;
    chr_tok.nest_depth    = dep_ext[DEPTH_W-1:0];
    chr_tok.last          = 1'b1;
  end

  // Character decode: state update and up to two tokens.
  always_comb begin
    logic flush;
    logic clear;
    flush     = 1'b0;
    clear     = 1'b0;
    acc_d     = acc_q;
    pend_d    = pend_q;
    sat_d     = sat_q;
    stk_cnt_d = stk_cnt_q;
    top_d     = top_q;
    stk_we    = 1'b0;
    stk_waddr = stk_cnt_q[AW-1:0];
    stk_wdata = oc;
    res1      = chr_tok;
    nres      = 2'd0;

    if (accept) begin
      if (c == CH_SPACE || c inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]}) begin
        nres = 2'd0;
      end else if (c == CH_NEWLINE || c == CH_EOL_ALT) begin
        flush         = 1'b1;
        clear         = 1'b1;
        res1.tok_kind = TK_LINE_END;
        res1.nest_depth = '0;
      end else if (c inside {CH_POW, CH_MUL, CH_DIV, CH_ADD, CH_SUB}) begin
        flush         = 1'b1;
        res1.tok_kind = TK_OPERATOR;
        case (c)
          CH_POW:         res1.prec_class = PREC_POWER;
          CH_MUL, CH_DIV: res1.prec_class = PREC_MULDIV;
          default:        res1.prec_class = PREC_ADDSUB;
        endcase
      end else if (c inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
        if (sat_q || (prod[NUM_WIDTH+3:NUM_WIDTH] != 4'd0)) begin
          acc_d = '1;
          sat_d = 1'b1;
        end else begin
          acc_d = prod[NUM_WIDTH-1:0];
        end
        pend_d = 1'b1;
      end else if (oc != BR_NONE) begin
        flush = 1'b1;
        if (stk_cnt_q >= CNT_W'(STACK_DEPTH)) begin
          clear           = 1'b1;
          res1.tok_kind   = TK_OVERFLOW;
          res1.nest_depth = '0;
        end else begin
          stk_we          = 1'b1;
          stk_cnt_d       = stk_cnt_q + CNT_W'(1);
          top_d           = oc;
          res1.tok_kind   = TK_OPEN;
          res1.nest_depth = dep_inc_ext[DEPTH_W-1:0];
        end
      end else if (cc != BR_NONE) begin
        flush = 1'b1;
        if (stk_cnt_q == '0) begin
          clear           = 1'b1;
          res1.tok_kind   = TK_UNMATCHED;
          res1.nest_depth = '0;
        end else if (top_q != cc) begin
          clear           = 1'b1;
          res1.tok_kind   = TK_MISMATCHED;
          res1.nest_depth = '0;
        end else begin
          stk_cnt_d       = stk_cnt_q - CNT_W'(1);
          top_d           = below_q;
          res1.tok_kind   = TK_CLOSE;
          res1.nest_depth = dep_dec_ext[DEPTH_W-1:0];
        end
      end else begin
        res1.tok_kind = TK_BAD_CHAR;
      end

      // Every non-digit, non-ignored character gives one character token.
      if (!(c == CH_SPACE || c inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z],
                                       [CH_DIGIT_0:CH_DIGIT_9]})) begin
        nres = (flush && pend_q) ? 2'd2 : 2'd1;
      end
      if (flush) begin
        acc_d  = '0;
        pend_d = 1'b0;
        sat_d  = 1'b0;
      end
      if (clear) begin
        acc_d     = '0;
        pend_d    = 1'b0;
        sat_d     = 1'b0;
        stk_cnt_d = '0;
      end
    end

    // Order the tokens: a flushed number comes first.
    res0 = (nres == 2'd2) ? num_tok : res1;
  end

  // Read address: the entry below the top after this transaction.
  assign rd_cnt    = stk_cnt_d - CNT_W'(2);
  assign stk_raddr = (stk_cnt_d >= CNT_W'(2)) ? rd_cnt[AW-1:0] : '0;

  // Stack memory with one write and one registered read.
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    below_q <= stk_mem[stk_raddr];
    top_q   <= top_d;
  end

  // Control state of the tokenizer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      pend_q    <= 1'b0;
      sat_q     <= 1'b0;
      stk_cnt_q <= '0;
    end else begin
      acc_q     <= acc_d;
      pend_q    <= pend_d;
      sat_q     <= sat_d;
      stk_cnt_q <= stk_cnt_d;
    end
  end

  // Result queue: shift on a pop, then append the new tokens.
  assign pop   = tok_o.valid && tok_o.ready;
  assign qbase = qcnt_q - QC_W'(pop);

  always_comb begin
    for (int i = 0; i < QD - 1; i++) begin
      q_sh[i] = pop ? q_q[i + 1] : q_q[i];
    end
    q_sh[QD-1] = q_q[QD-1];
    for (int i = 0; i < QD; i++) begin
      q_d[i] = q_sh[i];
      if (nres != 2'd0 && QC_W'(i) == qbase) begin
        q_d[i] = res0;
      end
      if (nres == 2'd2 && QC_W'(i) == qbase + QC_W'(1)) begin
        q_d[i] = res1;
      end
    end
    qcnt_d = qbase + {1'b0, nres};
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QD; i++) begin
      q_q[i] <= q_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qcnt_q <= '0;
    end else begin
      qcnt_q <= qcnt_d;
    end
  end

  // Output side.
  assign tok_o.valid         = (qcnt_q != '0);
  assign tok_o.tok_kind      = q_q[0].tok_kind;
  assign tok_o.tok_value     = q_q[0].tok_value;
  assign tok_o.prec_class    = q_q[0].prec_class;
  assign tok_o.num_saturated = q_q[0].num_saturated;
  assign tok_o.nest_depth    = q_q[0].nest_depth;
  assign tok_o.last          = q_q[0].last;

`ifndef ASSERT_OFF
  // The result queue never holds more tokens than it has slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni) qcnt_q <= QC_W'(QD))
    else $error("result queue overfilled");

  // The stack count never passes the stack depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   stk_cnt_q <= CNT_W'(STACK_DEPTH))
    else $error("bracket stack count out of range");

  // A number token is never the last token of a character, every other one is.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   tok_o.valid |-> ((q_q[0].tok_kind == TK_NUMBER) != q_q[0].last))
    else $error("last flag does not match token kind");

  // Error tokens report the cleared depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   tok_o.valid && (q_q[0].tok_kind == TK_UNMATCHED ||
                   q_q[0].tok_kind == TK_MISMATCHED || q_q[0].tok_kind == TK_OVERFLOW)
                   |-> q_q[0].nest_depth == '0)
    else $error("error token with nonzero depth");

  // A line end empties the stack and leaves no number pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   accept && (c == CH_NEWLINE || c == CH_EOL_ALT)
                   |=> stk_cnt_q == '0 && !pend_q)
    else $error("line end did not clear state");
`endif

endmodule
